// ===== rtl/kcs_pkg.sv =====
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types, sizes, register indexes and helpers for the k closest
// elements selector.
// ----------------------------------------------------------------------------
`default_nettype none

package kcs_pkg;

  // array and result sizes
  localparam int MAX_ELEMENTS = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int DATA_W       = 32;
  localparam int DIST_W       = DATA_W + 1;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int K_W          = 7;
  localparam int CMP_W        = (CNT_W > K_W) ? CNT_W : K_W;

  // configuration register indexes
  localparam int REG_W = 1;
  localparam logic [REG_W-1:0] REG_K_COUNT = 1'b0;
  localparam logic [REG_W-1:0] REG_TARGET  = 1'b1;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_SCAN,
    ST_GROW_RD,
    ST_GROW_DIST,
    ST_GROW_STEP,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD
  } state_t;

  // exact absolute difference of two signed words
  function automatic dist_t abs_diff(input word_t a, input word_t b);
    logic signed [DIST_W-1:0] d;
    d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    return d[DIST_W-1] ? dist_t'(-d) : dist_t'(d);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kcs_ram.sv =====
// ----------------------------------------------------------------------------
// kcs_ram
// Element store: one write port and two read ports, read data registered
// in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_ram (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire kcs_pkg::addr_t waddr,
  input  wire kcs_pkg::word_t wdata,
  input  wire kcs_pkg::addr_t ra_addr,
  input  wire kcs_pkg::addr_t rb_addr,
  output      kcs_pkg::word_t ra_data,
  output      kcs_pkg::word_t rb_data
);

  kcs_pkg::word_t mem [kcs_pkg::MAX_ELEMENTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/k_closest_in_sorted_array_top.sv =====
// ----------------------------------------------------------------------------
// k_closest_in_sorted_array_top
// Loads a sorted array and streams out the k elements nearest a target.
// ----------------------------------------------------------------------------
// Elements arrive one per request on the slave side and are taken one per
// cycle into a 64-entry store; the request marked tlast closes the array and
// the block stops taking requests until every result has been delivered.
// Selection then runs from the store through a single sequencer with a
// registered memory read: a set-up state, a scan for the nearest element
// when the target lies strictly inside the array's range, k window steps
// that each pass the read, distance and step states, and a read, wait and
// hold state per result, the hold lasting through master-side back-pressure.
// Elements past 64 are dropped, k of zero counts as one and k is clamped to
// the number loaded. Results come out in ascending index order and the last
// one carries tlast. Configuration writes belong in idle periods.
`default_nettype none

module k_closest_in_sorted_array_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // element input
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] element
  input  wire logic        s_tlast,   // is_last
  // result output
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // [31:0] chosen
  output      logic        m_tlast    // end_of_run
);

  localparam int CNT_W  = kcs_pkg::CNT_W;
  localparam int K_W    = kcs_pkg::K_W;
  localparam int CMP_W  = kcs_pkg::CMP_W;
  localparam int ADDR_W = kcs_pkg::ADDR_W;

  kcs_pkg::state_t state, state_next;

  // configuration registers
  logic [K_W-1:0]  k_count;
  kcs_pkg::word_t  target_value;

  // load bookkeeping
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n;
  kcs_pkg::word_t   first_elem;
  kcs_pkg::word_t   last_elem;
  logic [K_W-1:0]   k_eff;

  // scan pipeline
  logic [CNT_W-1:0] rd_idx;
  logic             p1_v, p2_v;
  kcs_pkg::addr_t   p1_idx, p2_idx;
  kcs_pkg::dist_t   dist2;
  kcs_pkg::addr_t   best;
  kcs_pkg::dist_t   best_dist;

  // window growth
  logic [CNT_W-1:0] left_p1;
  logic [CNT_W-1:0] right;
  logic [K_W-1:0]   steps;
  kcs_pkg::dist_t   dist_l, dist_r;

  // emission
  logic [CNT_W-1:0] first_idx;
  logic [K_W-1:0]   emit_idx;
  kcs_pkg::word_t   out_data;
  logic             out_last;

  // memory signals
  logic           mem_we;
  kcs_pkg::addr_t ra_addr, rb_addr;
  kcs_pkg::word_t ra_data, rb_data;
  logic [CNT_W-1:0] left_idx;
  logic [CNT_W-1:0] emit_addr;

  logic             in_req;
  logic             out_req;
  logic             has_room;
  logic             at_low, at_high;
  logic [K_W-1:0]   k_sel;
  logic [CMP_W-1:0] k_tmp;
  logic             scan_done;
  logic             take_left;
  logic             emit_last;

  kcs_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (count[ADDR_W-1:0]),
    .wdata   (s_tdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // request strobes and decisions
  always_comb begin
    in_req    = s_tvalid & s_tready;
    out_req   = m_tvalid & m_tready;
    has_room  = (count < CNT_W'(kcs_pkg::MAX_ELEMENTS));
    at_low    = ($signed(target_value) <= $signed(first_elem));
    at_high   = ($signed(target_value) >= $signed(last_elem));
    scan_done = (rd_idx == n) & ~p1_v & ~p2_v;
    emit_last = (emit_idx == (k_eff - K_W'(1)));
    priority if (left_p1 == '0) begin
      take_left = 1'b0;
    end else if (right >= n) begin
      take_left = 1'b1;
    end else begin
      take_left = (dist_l <= dist_r);
    end
  end

  // clamp k to [1, n] and to the result limit
  always_comb begin
    k_tmp = (k_count == '0) ? CMP_W'(1) : CMP_W'(k_count);
    if (k_tmp > CMP_W'(n)) begin
      k_tmp = CMP_W'(n);
    end
    if (k_tmp > CMP_W'(kcs_pkg::RESULT_LIMIT)) begin
      k_tmp = CMP_W'(kcs_pkg::RESULT_LIMIT);
    end
    k_sel = K_W'(k_tmp);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kcs_pkg::ST_LOAD: begin
        if (in_req && s_tlast) begin
          state_next = kcs_pkg::ST_SETUP;
        end
      end
      kcs_pkg::ST_SETUP: begin
        state_next = (at_low || at_high) ? kcs_pkg::ST_EMIT_RD : kcs_pkg::ST_SCAN;
      end
      kcs_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = kcs_pkg::ST_GROW_RD;
        end
      end
      kcs_pkg::ST_GROW_RD: begin
        state_next = (steps == k_eff) ? kcs_pkg::ST_EMIT_RD : kcs_pkg::ST_GROW_DIST;
      end
      kcs_pkg::ST_GROW_DIST: state_next = kcs_pkg::ST_GROW_STEP;
      kcs_pkg::ST_GROW_STEP: state_next = kcs_pkg::ST_GROW_RD;
      kcs_pkg::ST_EMIT_RD:   state_next = kcs_pkg::ST_EMIT_WAIT;
      kcs_pkg::ST_EMIT_WAIT: state_next = kcs_pkg::ST_EMIT_HOLD;
      kcs_pkg::ST_EMIT_HOLD: begin
        if (m_tready) begin
          state_next = out_last ? kcs_pkg::ST_LOAD : kcs_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = kcs_pkg::ST_LOAD;
    endcase
  end

  // outputs and memory addresses
  always_comb begin
    s_tready  = (state == kcs_pkg::ST_LOAD);
    m_tvalid  = (state == kcs_pkg::ST_EMIT_HOLD);
    m_tdata   = out_data;
    m_tlast   = out_last;
    mem_we    = s_tready & s_tvalid & has_room;
    left_idx  = left_p1 - CNT_W'(1);
    emit_addr = first_idx + CNT_W'(emit_idx);
    rb_addr   = right[ADDR_W-1:0];
    unique case (state)
      kcs_pkg::ST_GROW_RD: ra_addr = left_idx[ADDR_W-1:0];
      kcs_pkg::ST_EMIT_RD: ra_addr = emit_addr[ADDR_W-1:0];
      default:             ra_addr = rd_idx[ADDR_W-1:0];
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kcs_pkg::ST_LOAD;
      k_count      <= K_W'(1);
      target_value <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          kcs_pkg::REG_K_COUNT: k_count      <= cfg_wdata[K_W-1:0];
          kcs_pkg::REG_TARGET:  target_value <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // load counter and scan pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
    end else begin
      if (in_req) begin
        if (s_tlast) begin
          count <= '0;
        end else if (has_room) begin
          count <= count + CNT_W'(1);
        end
      end
      p1_v <= (state == kcs_pkg::ST_SCAN) && (rd_idx < n);
      p2_v <= p1_v;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // load: keep the end elements of the array
    if (mem_we) begin
      if (count == '0) begin
        first_elem <= s_tdata;
      end
      last_elem <= s_tdata;
    end
    if (in_req && s_tlast) begin
      n <= has_room ? (count + CNT_W'(1)) : count;
    end

    // scan pipeline payload
    p1_idx <= rd_idx[ADDR_W-1:0];
    p2_idx <= p1_idx;
    dist2  <= kcs_pkg::abs_diff(ra_data, target_value);

    unique case (state)
      kcs_pkg::ST_SETUP: begin
        k_eff     <= k_sel;
        best      <= '0;
        best_dist <= kcs_pkg::abs_diff(first_elem, target_value);
        rd_idx    <= CNT_W'(1);
        emit_idx  <= '0;
        if (at_low) begin
          first_idx <= '0;
        end else begin
          first_idx <= n - CNT_W'(k_sel);
        end
      end
      kcs_pkg::ST_SCAN: begin
        if (rd_idx < n) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        // first strictly smaller distance wins
        if (p2_v && (dist2 < best_dist)) begin
          best      <= p2_idx;
          best_dist <= dist2;
        end
        left_p1 <= CNT_W'(best);
        right   <= CNT_W'(best);
        steps   <= '0;
      end
      kcs_pkg::ST_GROW_RD: begin
        first_idx <= left_p1;
        emit_idx  <= '0;
      end
      kcs_pkg::ST_GROW_DIST: begin
        dist_l <= kcs_pkg::abs_diff(ra_data, target_value);
        dist_r <= kcs_pkg::abs_diff(rb_data, target_value);
      end
      kcs_pkg::ST_GROW_STEP: begin
        // widen the window by one, ties to the left
        if (take_left) begin
          left_p1 <= left_p1 - CNT_W'(1);
        end else begin
          right <= right + CNT_W'(1);
        end
        steps <= steps + K_W'(1);
      end
      kcs_pkg::ST_EMIT_WAIT: begin
        out_data <= ra_data;
        out_last <= emit_last;
      end
      kcs_pkg::ST_EMIT_HOLD: begin
        if (out_req) begin
          emit_idx <= emit_idx + K_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/kcs_checker.sv =====
// ----------------------------------------------------------------------------
// kcs_checker
// Port-level checks on the k closest elements selector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // no elements are taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while a result is shown");

  // closing request stops intake
  a_close_stops: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still ready after the closing request");

  // an ordinary element keeps the load going
  a_load_goes_on: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> s_tready && !m_tvalid)
    else $error("load interrupted by an unmarked element");

  // final result hands back to loading
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block not back to loading after the last result");

endmodule

bind k_closest_in_sorted_array_top kcs_checker u_kcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
